[rtl/pso_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, constants and helpers of the polyline stroke outline block.
// ----------------------------------------------------------------------------
package pso_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int HALF_WIDTH_RESET = 65536;
    localparam int STEP_LAST = 30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_RD_CUR,
        ST_RD_NEXT,
        ST_DIFF,
        ST_NORM,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_QSTORE,
        ST_EMIT_L,
        ST_REV_ADDR,
        ST_REV_EMIT
    } pso_state_t;

    typedef struct packed {
        logic in_write;
        logic lat_prev;
        logic lat_cur;
        logic lat_diff;
        logic norm_step;
        logic sq_x;
        logic sq_y;
        logic sqrt_step;
        logic mul;
        logic div_init;
        logic div_step;
        logic q_store;
        logic sel_y;
        logic off_clear;
        logic off_write;
        logic out_load;
        logic out_right;
        logic out_end;
    } pso_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic vec_zero;
        logic out_free;
    } pso_status_t;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/polyline_stroke_outline.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_outline
// Turns an open polyline into the closed outline of a stroke around it.
// ----------------------------------------------------------------------------
// Vertices arrive on the input channel (in_valid / in_stall), one transfer
// each, final_vertex marking the last one. While collecting, the block does
// not stall its input. On the final vertex of a polyline with two or
// more stored vertices the block stalls its input and emits the left points
// in forward order, then the right points in reverse order, on the output
// channel (out_valid / out_stall); outline_end marks the last point.
// A left point takes three memory reads and a difference; for a zero joint
// vector it then goes through a check straight to its output, else up to 29
// normalizing shifts plus a check, two squares, 31 square root steps and two
// divisions through one shared divider come first, then the output. Each
// right point takes an address step and an emit step. Vertices beyond MAX_VERTICES are
// dropped. The output register holds a point while out_stall is high and the
// sequencer waits for it to drain. Reset returns the sequencer to collecting,
// empties the vertex count and sets half_width to 1.0; memories are not
// cleared. Write half_width only while the block is idle.
// ----------------------------------------------------------------------------
module polyline_stroke_outline #(
    parameter int MAX_VERTICES = pso_pkg::MAX_VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] vertex_x,
    input  logic [31:0] vertex_y,
    input  logic        final_vertex,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] point_x,
    output logic [31:0] point_y,
    output logic        outline_end
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    pso_pkg::pso_cmd_t    cmd;
    pso_pkg::pso_status_t status;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;

    pso_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .final_vertex (final_vertex),
        .status       (status),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr)
    );

    pso_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .outline_end  (outline_end)
    );

endmodule

[rtl/pso_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_datapath
// Vertex and offset memories, normalization, square root, division and the
// output register of the stroke outline block.
// ----------------------------------------------------------------------------
module pso_datapath #(
    parameter int MAX_VERTICES = pso_pkg::MAX_VERTICES_DEF,
    parameter int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pso_pkg::pso_cmd_t   cmd,
    output pso_pkg::pso_status_t status,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic                cfg_wr_en,
    input  logic [30:0]         cfg_wr_data,
    input  logic [31:0]         vertex_x,
    input  logic [31:0]         vertex_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         point_x,
    output logic [31:0]         point_y,
    output logic                outline_end
);

    logic [63:0] store_mem [MAX_VERTICES];
    logic [63:0] off_mem [MAX_VERTICES];
    logic [63:0] store_rd_reg;
    logic [63:0] off_rd_reg;

    logic [30:0] hw_reg;
    logic [31:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [31:0] ax_reg, ay_reg;
    logic        nx_reg, ny_reg;
    logic [59:0] sq_reg;
    logic [60:0] v_reg, res_reg, bit_reg;
    logic [60:0] prod_reg;
    logic [30:0] rem_reg, low_reg, q_reg;
    logic [31:0] ox_reg, oy_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] point_x_reg, point_y_reg;
    logic        outline_end_reg;

    logic [31:0] rd_x, rd_y;
    logic [32:0] dx, dy, dx_neg, dy_neg;
    logic [31:0] or_a;
    logic [61:0] trial;
    logic [30:0] len;
    logic [29:0] a_sel;
    logic [61:0] num;
    logic [31:0] div_t, div_d;
    logic        div_ge;
    logic [31:0] q_ext, q_sgn;
    logic        q_neg;
    logic [32:0] lx, ly, rx, ry;
    logic        out_free;

    assign rd_x   = store_rd_reg[63:32];
    assign rd_y   = store_rd_reg[31:0];
    assign dx     = {rd_x[31], rd_x} - {prev_x_reg[31], prev_x_reg};
    assign dy     = {rd_y[31], rd_y} - {prev_y_reg[31], prev_y_reg};
    assign dx_neg = 33'd0 - dx;
    assign dy_neg = 33'd0 - dy;
    assign or_a   = ax_reg | ay_reg;
    assign trial  = {1'b0, res_reg} + {1'b0, bit_reg};
    assign len    = res_reg[30:0];
    assign a_sel  = cmd.sel_y ? ay_reg[29:0] : ax_reg[29:0];
    assign num    = {1'b0, prod_reg} + {32'd0, len[30:1]};
    assign div_t  = {rem_reg, low_reg[30]};
    assign div_d  = div_t - {1'b0, len};
    assign div_ge = div_t >= {1'b0, len};
    assign q_ext  = {1'b0, q_reg};
    assign q_neg  = cmd.sel_y ? ny_reg : nx_reg;
    assign q_sgn  = q_neg ? (32'd0 - q_ext) : q_ext;
    assign lx = {cur_x_reg[31], cur_x_reg} + {oy_reg[31], oy_reg};
    assign ly = {cur_y_reg[31], cur_y_reg} - {ox_reg[31], ox_reg};
    assign rx = {rd_x[31], rd_x} - {off_rd_reg[31], off_rd_reg[31:0]};
    assign ry = {rd_y[31], rd_y} + {off_rd_reg[63], off_rd_reg[63:32]};
    assign out_free = !out_valid_reg || !out_stall;

    assign status.norm_done = !(|or_a[31:30]) && or_a[29];
    assign status.vec_zero  = ~|or_a;
    assign status.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.in_write)
        begin
            store_mem[wr_addr] <= {vertex_x, vertex_y};
        end
        if (cmd.off_write)
        begin
            off_mem[wr_addr] <= {ox_reg, oy_reg};
        end
        store_rd_reg <= store_mem[rd_addr];
        off_rd_reg   <= off_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lat_prev)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.lat_cur)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
        end
        if (cmd.lat_diff)
        begin
            ax_reg <= dx[32] ? dx_neg[31:0] : dx[31:0];
            ay_reg <= dy[32] ? dy_neg[31:0] : dy[31:0];
            nx_reg <= dx[32];
            ny_reg <= dy[32];
        end
        else if (cmd.norm_step)
        begin
            if (|or_a[31:30])
            begin
                ax_reg <= ax_reg >> 1;
                ay_reg <= ay_reg >> 1;
            end
            else
            begin
                ax_reg <= ax_reg << 1;
                ay_reg <= ay_reg << 1;
            end
        end
        if (cmd.sq_x)
        begin
            sq_reg <= ax_reg[29:0] * ax_reg[29:0];
        end
        if (cmd.sq_y)
        begin
            v_reg   <= {1'b0, sq_reg} + ay_reg[29:0] * ay_reg[29:0];
            res_reg <= '0;
            bit_reg <= {1'b1, 60'd0};
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg   <= v_reg - trial[60:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mul)
        begin
            prod_reg <= hw_reg * a_sel;
        end
        if (cmd.div_init)
        begin
            rem_reg <= num[61:31];
            low_reg <= num[30:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_d[30:0] : div_t[30:0];
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[29:0], div_ge};
        end
        if (cmd.off_clear)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else if (cmd.q_store)
        begin
            if (cmd.sel_y)
            begin
                oy_reg <= q_sgn;
            end
            else
            begin
                ox_reg <= q_sgn;
            end
        end
        if (cmd.out_load && out_free)
        begin
            point_x_reg     <= cmd.out_right ? pso_pkg::sat32(rx) : pso_pkg::sat32(lx);
            point_y_reg     <= cmd.out_right ? pso_pkg::sat32(ry) : pso_pkg::sat32(ly);
            outline_end_reg <= cmd.out_end;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= 31'(pso_pkg::HALF_WIDTH_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hw_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign outline_end = outline_end_reg;

endmodule

[rtl/pso_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_ctrl
// Sequencer of the stroke outline block: vertex collection, per-vertex
// offset computation and the two output passes.
// ----------------------------------------------------------------------------
module pso_ctrl #(
    parameter int MAX_VERTICES = pso_pkg::MAX_VERTICES_DEF,
    parameter int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    parameter int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 final_vertex,
    input  pso_pkg::pso_status_t status,
    output pso_pkg::pso_cmd_t    cmd,
    output logic [AW-1:0]        rd_addr,
    output logic [AW-1:0]        wr_addr
);

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [AW-1:0] IDX_MAX = AW'(MAX_VERTICES - 1);

    pso_pkg::pso_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic [4:0]    step_reg, step_next;
    logic          sel_y_reg, sel_y_next;
    logic          room;

    assign room = count_reg < CNT_MAX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pso_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= '0;
            step_reg  <= '0;
            sel_y_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            step_reg  <= step_next;
            sel_y_reg <= sel_y_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        sel_y_next = sel_y_reg;
        cmd        = '0;
        cmd.sel_y  = sel_y_reg;
        rd_addr    = idx_reg;
        wr_addr    = idx_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            pso_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                wr_addr  = count_reg[AW-1:0];
                if (in_valid)
                begin
                    cmd.in_write = room;
                    if (final_vertex)
                    begin
                        count_next = '0;
                        if (count_reg != '0)
                        begin
                            last_next  = room ? count_reg[AW-1:0] : IDX_MAX;
                            idx_next   = '0;
                            state_next = pso_pkg::ST_RD_PREV;
                        end
                    end
                    else if (room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            pso_pkg::ST_RD_PREV:
            begin
                rd_addr    = (idx_reg == '0) ? idx_reg : idx_reg - 1'b1;
                state_next = pso_pkg::ST_RD_CUR;
            end
            pso_pkg::ST_RD_CUR:
            begin
                cmd.lat_prev = 1'b1;
                state_next   = pso_pkg::ST_RD_NEXT;
            end
            pso_pkg::ST_RD_NEXT:
            begin
                rd_addr     = (idx_reg == last_reg) ? idx_reg : idx_reg + 1'b1;
                cmd.lat_cur = 1'b1;
                state_next  = pso_pkg::ST_DIFF;
            end
            pso_pkg::ST_DIFF:
            begin
                cmd.lat_diff = 1'b1;
                sel_y_next   = 1'b0;
                state_next   = pso_pkg::ST_NORM;
            end
            pso_pkg::ST_NORM:
            begin
                if (status.vec_zero)
                begin
                    cmd.off_clear = 1'b1;
                    state_next    = pso_pkg::ST_EMIT_L;
                end
                else if (status.norm_done)
                begin
                    state_next = pso_pkg::ST_SQ_X;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            pso_pkg::ST_SQ_X:
            begin
                cmd.sq_x   = 1'b1;
                state_next = pso_pkg::ST_SQ_Y;
            end
            pso_pkg::ST_SQ_Y:
            begin
                cmd.sq_y   = 1'b1;
                step_next  = '0;
                state_next = pso_pkg::ST_SQRT;
            end
            pso_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == 5'(pso_pkg::STEP_LAST))
                begin
                    state_next = pso_pkg::ST_MUL;
                end
            end
            pso_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = pso_pkg::ST_DIV_INIT;
            end
            pso_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = pso_pkg::ST_DIV;
            end
            pso_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == 5'(pso_pkg::STEP_LAST))
                begin
                    state_next = pso_pkg::ST_QSTORE;
                end
            end
            pso_pkg::ST_QSTORE:
            begin
                cmd.q_store = 1'b1;
                if (sel_y_reg)
                begin
                    state_next = pso_pkg::ST_EMIT_L;
                end
                else
                begin
                    sel_y_next = 1'b1;
                    state_next = pso_pkg::ST_MUL;
                end
            end
            pso_pkg::ST_EMIT_L:
            begin
                cmd.off_write = 1'b1;
                cmd.out_load  = 1'b1;
                if (status.out_free)
                begin
                    if (idx_reg == last_reg)
                    begin
                        state_next = pso_pkg::ST_REV_ADDR;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = pso_pkg::ST_RD_PREV;
                    end
                end
            end
            pso_pkg::ST_REV_ADDR:
            begin
                state_next = pso_pkg::ST_REV_EMIT;
            end
            pso_pkg::ST_REV_EMIT:
            begin
                cmd.out_load  = 1'b1;
                cmd.out_right = 1'b1;
                cmd.out_end   = (idx_reg == '0);
                if (status.out_free)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = pso_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = pso_pkg::ST_REV_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = pso_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/pso_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_checker
// Port-level checks of the stroke outline block.
// ----------------------------------------------------------------------------
module pso_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic        outline_end
);

    // stalled point holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(outline_end))
        else $error("stalled output point changed");

    // input is blocked while an outline is still being produced
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !outline_end |-> in_stall)
        else $error("input open during outline output");

    // a closing point is never directly followed by another closing point
    a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && outline_end |=> !(out_valid && outline_end))
        else $error("closing point repeated");

    // no output while in reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind polyline_stroke_outline pso_checker u_pso_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .outline_end (outline_end)
);
